FILE: hdl/greedy_graph_coloring_engine_macros.svh
// Assertion macros for the greedy graph coloring engine checker.
`ifndef GREEDY_GRAPH_COLORING_ENGINE_MACROS_SVH
`define GREEDY_GRAPH_COLORING_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define GGE_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("gge check failed: same-cycle implication");

// Next-cycle implication, sampled on clock, off during reset.
`define GGE_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("gge check failed: next-cycle implication");

`endif

FILE: hdl/gge_pkg.sv
// Shared types, constants and the lowest-free-color search for the coloring engine.
package gge_pkg;

   localparam int NUM_VERTICES = 1024;
   localparam int VTX_W        = $clog2(NUM_VERTICES);
   localparam int MAX_COLORS   = 64;
   localparam int COLOR_W      = $clog2(MAX_COLORS);
   localparam int COUNT_W      = COLOR_W + 1;
   localparam int GROUP_SIZE   = 8;
   localparam int NUM_GROUPS   = MAX_COLORS / GROUP_SIZE;
   localparam int GRP_W        = $clog2(NUM_GROUPS);
   localparam int BIT_W        = $clog2(GROUP_SIZE);

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   typedef struct packed {
      logic             op;
      logic [VTX_W-1:0] vertex;
      logic [VTX_W-1:0] neighbor;
      logic             has_neighbor;
      logic             last_of_vertex;
   } req_type;

   typedef struct packed {
      logic [VTX_W-1:0]   colored_vertex;
      logic [COLOR_W-1:0] chosen_color;
      logic [COUNT_W-1:0] colors_used;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic               mark;
      logic [COLOR_W-1:0] color;
   } entry_type;

   typedef struct packed {
      logic               clear;
      logic               step;
      logic               last;
      logic               hit;
      logic [COLOR_W-1:0] color;
   } mask_ctl_type;

   typedef struct packed {
      logic               overflow;
      logic [COLOR_W-1:0] color;
   } pick_type;

   // Two-level find-first-zero: first group with a free color, then the bit in it.
   function automatic pick_type lowest_free(input logic [MAX_COLORS-1:0] mask);
      logic [NUM_GROUPS-1:0] full;
      logic [GRP_W-1:0]      g_sel;
      logic [BIT_W-1:0]      b_sel;
      logic [GROUP_SIZE-1:0] grp;
      pick_type              res;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         full[g] = &mask[g*GROUP_SIZE +: GROUP_SIZE];
      end
      g_sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (!full[g]) g_sel = GRP_W'(g);
      end
      grp   = mask[g_sel*GROUP_SIZE +: GROUP_SIZE];
      b_sel = '0;
      for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
         if (!grp[b]) b_sel = BIT_W'(b);
      end
      res.overflow = &full;
      res.color    = res.overflow ? COLOR_W'(MAX_COLORS - 1) : {g_sel, b_sel};
      return res;
   endfunction

endpackage

FILE: hdl/gge_color_mem.sv
// Per-vertex color memory: colored mark and color, one write and one registered read port.
module gge_color_mem (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [gge_pkg::VTX_W-1:0] rd_addr,
   output gge_pkg::entry_type        rd_data,
   input  logic                      wr_en,
   input  logic [gge_pkg::VTX_W-1:0] wr_addr,
   input  gge_pkg::entry_type        wr_data
);
   import gge_pkg::*;

   entry_type mem_ff [NUM_VERTICES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/gge_mask_unit.sv
// Used-color mask, running color count and lowest-free color choice.
module gge_mask_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  gge_pkg::mask_ctl_type       ctl,
   output gge_pkg::pick_type           pick,
   output logic [gge_pkg::COUNT_W-1:0] count_next
);
   import gge_pkg::*;

   logic [MAX_COLORS-1:0] used_mask_ff, used_mask_in, mask_next;
   logic [COUNT_W-1:0]    count_ff, count_in, pick_count;

   always_comb begin
      mask_next = used_mask_ff;
      if (ctl.hit) mask_next = used_mask_ff | (MAX_COLORS'(1) << ctl.color);
   end

   assign pick       = lowest_free(mask_next);
   assign pick_count = COUNT_W'(pick.color) + COUNT_W'(1);

   always_comb begin
      used_mask_in = used_mask_ff;
      count_in     = count_ff;
      if (ctl.clear) begin
         used_mask_in = '0;
         count_in     = '0;
      end else if (ctl.step) begin
         // drop the mask once the vertex has its color
         used_mask_in = ctl.last ? '0 : mask_next;
         if (ctl.last && pick_count > count_ff) count_in = pick_count;
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_mask_ff <= '0;
         count_ff     <= '0;
      end else begin
         used_mask_ff <= used_mask_in;
         count_ff     <= count_in;
      end
   end

endmodule

FILE: hdl/greedy_graph_coloring_engine.sv
// Greedy graph coloring engine: a step request first reads the neighbor's entry from the
// color memory, then folds it into the used-color mask and, on the last request of a
// vertex, picks and stores the lowest free color; busy is high during that second step.
// The result strobes on rsp_valid for one cycle in the cycle after that, and a new request
// may be taken in the same cycle. A clear request sweeps the memory's colored marks, one
// entry per cycle, and holds busy high until all 1024 entries are cleared; after reset busy
// is high while the same sweep runs. Results cannot be stalled.
module greedy_graph_coloring_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gge_pkg::req_type req_data,
   output logic             rsp_valid,
   output gge_pkg::rsp_type rsp_data
);
   import gge_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_STEP  = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [VTX_W-1:0] sweep_cnt_ff, sweep_cnt_in;
   req_type          item_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             accept, nbr_in_range, vtx_in_range;
   entry_type        rd_entry, wr_entry;
   logic             wr_en;
   logic [VTX_W-1:0] wr_addr;
   mask_ctl_type     ctl;
   pick_type         pick;
   logic [COUNT_W-1:0] count_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign nbr_in_range = ({1'b0, item_ff.neighbor} < (VTX_W+1)'(NUM_VERTICES));
   assign vtx_in_range = ({1'b0, item_ff.vertex} < (VTX_W+1)'(NUM_VERTICES));

   gge_color_mem u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_data.neighbor),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry)
   );

   always_comb begin
      ctl.clear = accept && (req_data.op == OP_CLEAR);
      ctl.step  = (state_ff == ST_STEP);
      ctl.last  = item_ff.last_of_vertex;
      ctl.hit   = item_ff.has_neighbor && nbr_in_range && rd_entry.mark;
      ctl.color = rd_entry.color;
   end

   gge_mask_unit u_mask (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .pick       (pick),
      .count_next (count_next)
   );

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = sweep_cnt_ff;
      wr_entry = '0;
      if (state_ff == ST_SWEEP) begin
         wr_en = 1'b1;
      end else if (ctl.step && ctl.last && vtx_in_range) begin
         wr_en          = 1'b1;
         wr_addr        = item_ff.vertex;
         wr_entry.mark  = 1'b1;
         wr_entry.color = pick.color;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_CLEAR) begin
                  state_in     = ST_SWEEP;
                  sweep_cnt_in = '0;
               end else begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            state_in = ST_IDLE;
         end
         ST_SWEEP: begin
            sweep_cnt_in = sweep_cnt_ff + VTX_W'(1);
            if (sweep_cnt_ff == VTX_W'(NUM_VERTICES - 1)) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in          = ctl.step && ctl.last;
      rsp_in.colored_vertex = item_ff.vertex;
      rsp_in.chosen_color   = pick.color;
      rsp_in.colors_used    = count_next;
      rsp_in.overflow       = pick.overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= req_data;
      if (rsp_valid_in) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/gge_checker.sv
// Port-level checker for the coloring engine, bound to the top level.
`include "greedy_graph_coloring_engine_macros.svh"

module gge_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input gge_pkg::rsp_type rsp_data
);
   import gge_pkg::*;

   `GGE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   `GGE_ASSERT_NOW(a_rsp_after_busy, rsp_valid, $past(busy) && !busy)
   `GGE_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid)
   `GGE_ASSERT_NOW(a_count_covers, rsp_valid, rsp_data.colors_used > COUNT_W'(rsp_data.chosen_color))

endmodule

bind greedy_graph_coloring_engine gge_checker u_gge_checker (.*);
